// ===== rtl/bitset_lazy_flip_counter_unit_assert.svh =====
// Assertion macros used by the bit store RTL.
`ifndef BITSET_LAZY_FLIP_COUNTER_UNIT_ASSERT_SVH
`define BITSET_LAZY_FLIP_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BLFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BLFC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/blfc_pkg.sv =====
// Package: constants, codes, payload types and helpers of the bit store.
`default_nettype none

package blfc_pkg;

    localparam int MAX_BITS   = 1024;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(WORD_COUNT);
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [PADDR_W-3:0] REG_ACTIVE_BITS = 1'b0;

    typedef enum logic [1:0] {
        CMD_FIX   = 2'd0,
        CMD_UNFIX = 2'd1,
        CMD_FLIP  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_MODIFY = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd             command;
        logic [IDX_W-1:0] bit_index;
    } t_in_item;

    typedef struct packed {
        logic             all_set;
        logic             any_set;
        logic [CNT_W-1:0] ones_count;
        logic             index_error;
    } t_out_item;

    function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (r == '0) begin
            r = CNT_W'(1);
        end
        if (r > CNT_W'(MAX_BITS)) begin
            r = CNT_W'(MAX_BITS);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/blfc_word_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none

module blfc_word_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bitset_lazy_flip_counter_unit.sv =====
// Bit store of up to 1024 bits with lazy global inversion and a running count of ones.
// Per item: on accept (ST_IDLE) the addressed 32-bit word is read from the word memory;
// in ST_MODIFY, once the result register is empty or being taken, the word is written back
// if a bit changes, the count and inversion flag are updated and the result register is
// loaded. One item is in flight at a time, as ST_MODIFY accepts none. The result register
// lets the next item be accepted while a result still waits to be taken. Per-word valid
// flags clear the whole store at reset and on every write of active_bits, so no clearing
// pass runs. The user must write active_bits (byte address 0) only while idle; the block
// does not enforce it. Only pwdata[10:0] is used: zero is taken as 1, above 1024 as 1024.
`default_nettype none

`include "bitset_lazy_flip_counter_unit_assert.svh"

module bitset_lazy_flip_counter_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire blfc_pkg::t_in_item               i_in_item,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output blfc_pkg::t_out_item                   o_out_item,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [blfc_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [blfc_pkg::PDATA_W-1:0]     pwdata,
    output logic      [blfc_pkg::PDATA_W-1:0]     prdata,
    output logic                                  pready
);

    import blfc_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [CNT_W-1:0]       r_active_bits;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_inverted;
    logic [WORD_COUNT-1:0]  r_word_vld;
    t_cmd                   r_cmd;
    logic [BIT_AW-1:0]      r_bit_sel;
    logic [WORD_AW-1:0]     r_word_addr;
    logic                   r_err;
    logic                   r_vld_rd;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic                   in_fire;
    logic                   complete;
    logic                   cfg_we;
    logic                   cfg_hit;
    logic [IDX_W-1:0]       idx_shift;
    logic [WORD_AW-1:0]     rd_addr;
    logic                   in_is_fu;
    logic                   in_err;
    logic [WORD_BITS-1:0]   rd_data;
    logic [WORD_BITS-1:0]   word_cur;
    logic [WORD_BITS-1:0]   bit_mask;
    logic                   logical;
    logic                   want;
    logic                   is_fu;
    logic                   is_flip;
    logic                   change;
    logic                   wr_en;

    // configuration port
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_hit = (paddr[PADDR_W-1:2] == REG_ACTIVE_BITS);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? PDATA_W'(r_active_bits) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bits <= clamp_size(CNT_W'(MAX_BITS));
        end else if (cfg_we && cfg_hit) begin
            r_active_bits <= clamp_size(pwdata[CNT_W-1:0]);
        end
    end

    // sequencer
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid & o_in_ready;
    assign complete   = (r_state == ST_MODIFY) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                if (complete) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // read side: capture the item and read its word
    assign idx_shift = i_in_item.bit_index >> BIT_AW;
    assign rd_addr   = idx_shift[WORD_AW-1:0];
    assign in_is_fu  = (i_in_item.command == CMD_FIX) || (i_in_item.command == CMD_UNFIX);
    assign in_err    = in_is_fu && ({1'b0, i_in_item.bit_index} >= r_active_bits);

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd       <= i_in_item.command;
            r_bit_sel   <= i_in_item.bit_index[BIT_AW-1:0];
            r_word_addr <= rd_addr;
            r_err       <= in_err;
            r_vld_rd    <= r_word_vld[rd_addr];
        end
    end

    blfc_word_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_word_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_word_addr),
        .i_wr_data (word_cur ^ bit_mask),
        .i_rd_en   (in_fire),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // modify side
    assign word_cur = r_vld_rd ? rd_data : '0;
    assign bit_mask = WORD_BITS'(1) << r_bit_sel;
    assign logical  = word_cur[r_bit_sel] ^ r_inverted;
    assign want     = (r_cmd == CMD_FIX);
    assign is_fu    = (r_cmd == CMD_FIX) || (r_cmd == CMD_UNFIX);
    assign is_flip  = (r_cmd == CMD_FLIP);
    assign change   = is_fu && !r_err && (logical != want);
    assign wr_en    = complete && change;

    always_comb begin
        n_count = r_count;
        if (change) begin
            n_count = want ? (r_count + CNT_W'(1)) : (r_count - CNT_W'(1));
        end else if (is_flip) begin
            n_count = r_active_bits - r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_inverted <= 1'b0;
            r_word_vld <= '0;
        end else if (cfg_we && cfg_hit) begin
            r_count    <= '0;
            r_inverted <= 1'b0;
            r_word_vld <= '0;
        end else if (complete) begin
            r_count <= n_count;
            if (is_flip) begin
                r_inverted <= ~r_inverted;
            end
            if (change) begin
                r_word_vld[r_word_addr] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (complete) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (complete) begin
            r_out_item.all_set     <= (n_count == r_active_bits);
            r_out_item.any_set     <= (n_count != '0);
            r_out_item.ones_count  <= n_count;
            r_out_item.index_error <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `BLFC_ASSERT_IMP(a_count_in_range, 1'b1, r_count <= r_active_bits)
    `BLFC_ASSERT_NXT(a_accept_starts_modify, in_fire, r_state == ST_MODIFY)
    `BLFC_ASSERT_NXT(a_complete_loads_result, complete, r_out_valid)
    `BLFC_ASSERT_IMP(a_no_write_on_error, r_err && (r_state == ST_MODIFY), !wr_en)

endmodule

`default_nettype wire

// ===== tb/bitset_flip_checker.sv =====
// Checker for the bit store: predicts each result and compares it with the output transfers.
module bitset_flip_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_ready,
    input  wire blfc_pkg::t_in_item               i_in_item,
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_ready,
    input  wire blfc_pkg::t_out_item              i_out_item,
    input  wire logic                             i_psel,
    input  wire logic                             i_penable,
    input  wire logic                             i_pwrite,
    input  wire logic                             i_pready,
    input  wire logic [blfc_pkg::PADDR_W-1:0]     i_paddr,
    input  wire logic [blfc_pkg::PDATA_W-1:0]     i_pwdata,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    import blfc_pkg::*;

    logic [WORD_BITS-1:0] stored_words [WORD_COUNT];
    logic [CNT_W-1:0]     ones_now;
    logic [CNT_W-1:0]     bits_in_use;
    logic                 flipped;
    t_out_item            pending_results [$];
    int                   mismatches = 0;

    function automatic void clear_bits();
        for (int w = 0; w < WORD_COUNT; w++) begin
            stored_words[w] = '0;
        end
        ones_now = '0;
        flipped  = 1'b0;
    endfunction

    function automatic t_out_item apply_command(input t_in_item item);
        t_out_item              res;
        logic [WORD_AW-1:0]     word_sel;
        logic [BIT_AW-1:0]      bit_sel;
        logic                   current;
        logic                   wanted;
        res      = '0;
        word_sel = item.bit_index[IDX_W-1:BIT_AW];
        bit_sel  = item.bit_index[BIT_AW-1:0];
        case (item.command)
            CMD_FIX, CMD_UNFIX: begin
                if (CNT_W'(item.bit_index) >= bits_in_use) begin
                    res.index_error = 1'b1;
                end else begin
                    current = stored_words[word_sel][bit_sel] ^ flipped;
                    wanted  = (item.command == CMD_FIX);
                    if (current != wanted) begin
                        stored_words[word_sel][bit_sel] = ~stored_words[word_sel][bit_sel];
                        ones_now = wanted ? ones_now + 1'b1 : ones_now - 1'b1;
                    end
                end
            end
            CMD_FLIP: begin
                flipped  = ~flipped;
                ones_now = bits_in_use - ones_now;
            end
            default: begin
            end
        endcase
        res.all_set    = (ones_now == bits_in_use);
        res.any_set    = (ones_now != '0);
        res.ones_count = ones_now;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item        expected;
        logic [CNT_W-1:0] new_size;
        if (!i_rst_n) begin
            clear_bits();
            bits_in_use = CNT_W'(MAX_BITS);
            pending_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[PADDR_W-1:2] == REG_ACTIVE_BITS) begin
                new_size = i_pwdata[CNT_W-1:0];
                if (new_size == '0) begin
                    new_size = CNT_W'(1);
                end
                if (new_size > CNT_W'(MAX_BITS)) begin
                    new_size = CNT_W'(MAX_BITS);
                end
                bits_in_use = new_size;
                clear_bits();
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result transfer: all=%0d any=%0d ones=%0d err=%0d",
                                 i_out_item.all_set, i_out_item.any_set,
                                 i_out_item.ones_count, i_out_item.index_error);
                    end
                    mismatches++;
                end else begin
                    expected = pending_results.pop_front();
                    if (i_out_item.all_set !== expected.all_set
                            || i_out_item.any_set !== expected.any_set
                            || i_out_item.ones_count !== expected.ones_count
                            || i_out_item.index_error !== expected.index_error) begin
                        if (mismatches < 10) begin
                            $display("mismatch: expected all=%0d any=%0d ones=%0d err=%0d",
                                     expected.all_set, expected.any_set,
                                     expected.ones_count, expected.index_error);
                            $display("          actual   all=%0d any=%0d ones=%0d err=%0d",
                                     i_out_item.all_set, i_out_item.any_set,
                                     i_out_item.ones_count, i_out_item.index_error);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(apply_command(i_in_item));
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the bit store testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
    import blfc_pkg::*;

    localparam int                 LIMIT_CYCLES = 200000;
    localparam int                 PHASE_ITEMS  = 130;
    localparam logic [PADDR_W-3:0] REG_UNUSED   = 1'b1;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    t_in_item            in_item  = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_item           out_item;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;
    int                  in_transfers = 0;
    int                  hold_left    = 0;
    int                  holds_done   = 0;
    int                  rx_mode      = 0;
    int                  mode_left    = 0;

    bitset_lazy_flip_counter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    bitset_flip_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        for (int cyc = 0; cyc < LIMIT_CYCLES; cyc++) begin
            @(posedge clk);
        end
        $display("** bitset_lazy_flip_counter_unit: FAILED **");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            in_transfers <= in_transfers + 1;
        end
    end

    // hold off twice for a long stretch so the block backs up into its input
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (holds_done < 2 && in_transfers >= 300 + 400 * holds_done) begin
            out_ready <= 1'b0;
            hold_left = 150;
            holds_done++;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic send_item(input t_cmd cmd, input logic [IDX_W-1:0] idx);
        in_valid <= 1'b1;
        in_item  <= '{command: cmd, bit_index: idx};
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-3:0] reg_index,
                             input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int               sizes [8];
        int               size_now;
        int               burst_left;
        int               pick;
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;

        sizes = '{1024, 1, 2, 31, 32, 33, 1023, 0};
        sizes[7] = $urandom_range(1, 1024);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_QUERY, 10'd0);
        send_item(CMD_FIX,   10'd0);
        send_item(CMD_FIX,   10'd1023);
        send_item(CMD_FIX,   10'd1023);
        send_item(CMD_UNFIX, 10'd1023);
        send_item(CMD_UNFIX, 10'd512);
        send_item(CMD_FLIP,  10'd0);
        send_item(CMD_QUERY, 10'd1023);
        send_item(CMD_FIX,   10'd0);
        send_item(CMD_UNFIX, 10'd1);
        send_item(CMD_FLIP,  10'd7);
        settle();

        write_reg(REG_ACTIVE_BITS, 32'd0);
        send_item(CMD_FIX,   10'd0);
        send_item(CMD_FIX,   10'd1);
        send_item(CMD_UNFIX, 10'd1023);
        send_item(CMD_FLIP,  10'd0);
        send_item(CMD_QUERY, 10'd1023);
        send_item(CMD_UNFIX, 10'd0);
        settle();

        write_reg(REG_UNUSED, 32'd5);
        send_item(CMD_FIX,   10'd0);
        send_item(CMD_QUERY, 10'd3);
        settle();

        write_reg(REG_ACTIVE_BITS, 32'hFFFF_FFFF);
        send_item(CMD_FLIP,  10'd0);
        send_item(CMD_UNFIX, 10'd1023);
        send_item(CMD_FIX,   10'd1023);
        settle();

        foreach (sizes[p]) begin
            size_now = sizes[p];
            write_reg(REG_ACTIVE_BITS, {21'($urandom() >> 11), 11'(size_now)});
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                    burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
                end
                pick = $urandom_range(0, 19);
                cmd  = (pick < 8)  ? CMD_FIX :
                       (pick < 15) ? CMD_UNFIX :
                       (pick < 17) ? CMD_FLIP : CMD_QUERY;
                if ($urandom_range(0, 9) == 0) begin
                    idx = IDX_W'($urandom_range(0, 1023));
                end else begin
                    idx = IDX_W'($urandom_range(0, size_now - 1));
                end
                send_item(cmd, idx);
                burst_left--;
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("** bitset_lazy_flip_counter_unit: PASSED **");
        end else begin
            $display("** bitset_lazy_flip_counter_unit: FAILED **");
        end
        $finish;
    end

endmodule
